// ===== rtl/core/ipf_pkg.sv =====
// shared types and codes for the five-set packet filter
package ipf_pkg;

  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 8;
  localparam int KEY_W   = 32;
  localparam int NUM_SETS = 5;

  // input opcode values
  localparam logic [1:0] OPC_CLASSIFY = 2'd0;
  localparam logic [1:0] OPC_INSERT   = 2'd1;
  localparam logic [1:0] OPC_ERASE    = 2'd2;

  // set select values
  localparam logic [2:0] SEL_SRC_IP   = 3'd0;
  localparam logic [2:0] SEL_DST_IP   = 3'd1;
  localparam logic [2:0] SEL_SRC_PORT = 3'd2;
  localparam logic [2:0] SEL_DST_PORT = 3'd3;
  localparam logic [2:0] SEL_PROTO    = 3'd4;

  // one-hot set positions
  localparam int SET_SRC_IP   = 0;
  localparam int SET_DST_IP   = 1;
  localparam int SET_SRC_PORT = 2;
  localparam int SET_DST_PORT = 3;
  localparam int SET_PROTO    = 4;

  localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_UDP   = 2'd1;
  localparam logic [1:0] KIND_TCP   = 2'd2;
  localparam logic [1:0] KIND_ICMP  = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLASSIFY,
    OP_INSERT,
    OP_ERASE,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         set_select;
    logic [KEY_W-1:0]   key_value;
    logic [IP_W-1:0]    src_address;
    logic [IP_W-1:0]    dst_address;
    logic [PROTO_W-1:0] proto_number;
    logic [PORT_W-1:0]  src_port_num;
    logic [PORT_W-1:0]  dst_port_num;
  } in_word_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] transport_kind;
    logic       status;
  } out_word_t;

  // decoded word handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [NUM_SETS-1:0] sel;
    logic [1:0]          kind;
    logic [KEY_W-1:0]    key_value;
    logic [IP_W-1:0]     src_address;
    logic [IP_W-1:0]     dst_address;
    logic [PROTO_W-1:0]  proto_number;
    logic [PORT_W-1:0]   src_port_num;
    logic [PORT_W-1:0]   dst_port_num;
  } work_t;

endpackage

// ===== rtl/core/ipf_front.sv =====
// front end: accepts input words, decodes them and queues them for the back end
module ipf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  ipf_pkg::in_word_t in_word,
  output logic             work_valid,
  input  logic             work_pop,
  output ipf_pkg::work_t   work
);
  import ipf_pkg::*;

  work_t               q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;
  work_t               dec;
  logic [NUM_SETS-1:0] sel_oh;

  always_comb begin
    sel_oh = '0;
    unique case (in_word.set_select)
      SEL_SRC_IP:   sel_oh[SET_SRC_IP]   = 1'b1;
      SEL_DST_IP:   sel_oh[SET_DST_IP]   = 1'b1;
      SEL_SRC_PORT: sel_oh[SET_SRC_PORT] = 1'b1;
      SEL_DST_PORT: sel_oh[SET_DST_PORT] = 1'b1;
      SEL_PROTO:    sel_oh[SET_PROTO]    = 1'b1;
      default:      sel_oh = '0;
    endcase
  end

  always_comb begin
    dec.sel          = sel_oh;
    dec.key_value    = in_word.key_value;
    dec.src_address  = in_word.src_address;
    dec.dst_address  = in_word.dst_address;
    dec.proto_number = in_word.proto_number;
    dec.src_port_num = in_word.src_port_num;
    dec.dst_port_num = in_word.dst_port_num;
    unique case (in_word.opcode)
      OPC_CLASSIFY: dec.op = OP_CLASSIFY;
      OPC_INSERT:   dec.op = (|sel_oh) ? OP_INSERT : OP_NONE;
      OPC_ERASE:    dec.op = (|sel_oh) ? OP_ERASE : OP_NONE;
      default:      dec.op = OP_NONE;
    endcase
    unique case (in_word.proto_number)
      PROTO_UDP:  dec.kind = KIND_UDP;
      PROTO_TCP:  dec.kind = KIND_TCP;
      PROTO_ICMP: dec.kind = KIND_ICMP;
      default:    dec.kind = KIND_OTHER;
    endcase
  end

  assign in_full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_push && !in_full;
  assign work_valid = (cnt_r != '0);
  assign pop        = work_pop && work_valid;
  assign work       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("work queue count beyond depth");

endmodule

// ===== rtl/core/ipf_set.sv =====
// one match set: slot keys, valid bits, parallel lookup, insert and erase
module ipf_set #(
  parameter int SIZE = 16,
  parameter int W    = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] key,
  input  logic         do_insert,
  input  logic         do_erase,
  output logic         hit,
  output logic         is_empty,
  output logic         is_full
);

  logic [W-1:0]    key_r [SIZE];
  logic [SIZE-1:0] used_r, used_nxt;
  logic [SIZE-1:0] match;
  logic [SIZE-1:0] free_lo;
  logic            ins_go;

  always_comb begin
    for (int i = 0; i < SIZE; i++) begin
      match[i] = used_r[i] && (key_r[i] == key);
    end
  end

  assign hit      = |match;
  assign is_empty = ~|used_r;
  assign is_full  = &used_r;
  // lowest free slot as a one-hot mask
  assign free_lo  = ~used_r & (used_r + SIZE'(1));
  assign ins_go   = do_insert && !hit && !is_full;

  always_comb begin
    used_nxt = used_r;
    if (ins_go) begin
      used_nxt = used_r | free_lo;
    end else if (do_erase) begin
      used_nxt = used_r & ~match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SIZE; i++) begin
      if (ins_go && free_lo[i]) begin
        key_r[i] <= key;
      end
    end
  end

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go |=> $countones(used_r) == $countones($past(used_r)) + 1)
    else $error("insert did not take exactly one slot");

  a_erase_hit: assert property (@(posedge clk) disable iff (!rst_n)
    do_erase && !do_insert && hit |=> $countones(used_r) < $countones($past(used_r)))
    else $error("erase of present key left set unchanged");

endmodule

// ===== rtl/core/ipf_back.sv =====
// back end: runs queued words against the five sets and queues results
module ipf_back #(
  parameter int IP_SET_SIZE    = 16,
  parameter int PORT_SET_SIZE  = 16,
  parameter int PROTO_SET_SIZE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               work_valid,
  output logic               work_pop,
  input  ipf_pkg::work_t     work,
  output logic               out_empty,
  input  logic               out_pop,
  output ipf_pkg::out_word_t out_word
);
  import ipf_pkg::*;

  logic [NUM_SETS-1:0] hit, empty, full, ins, ers;
  logic                classify, fire, pop;
  logic                base_ok, ports_ok, no_ports;
  out_word_t           res;
  out_word_t           rq_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IP_W-1:0]     k_sip, k_dip;
  logic [PORT_W-1:0]   k_sp, k_dp;
  logic [PROTO_W-1:0]  k_pr;

  assign fire     = work_valid && (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign work_pop = fire;
  assign classify = (work.op == OP_CLASSIFY);
  assign ins      = (fire && work.op == OP_INSERT) ? work.sel : '0;
  assign ers      = (fire && work.op == OP_ERASE) ? work.sel : '0;

  // classify probes with header fields, edits with the truncated key
  assign k_sip = classify ? work.src_address  : work.key_value[IP_W-1:0];
  assign k_dip = classify ? work.dst_address  : work.key_value[IP_W-1:0];
  assign k_sp  = classify ? work.src_port_num : work.key_value[PORT_W-1:0];
  assign k_dp  = classify ? work.dst_port_num : work.key_value[PORT_W-1:0];
  assign k_pr  = classify ? work.proto_number : work.key_value[PROTO_W-1:0];

  ipf_set #(.SIZE(IP_SET_SIZE), .W(IP_W)) u_src_ip (
    .clk, .rst_n, .key(k_sip), .do_insert(ins[SET_SRC_IP]), .do_erase(ers[SET_SRC_IP]),
    .hit(hit[SET_SRC_IP]), .is_empty(empty[SET_SRC_IP]), .is_full(full[SET_SRC_IP]));
  ipf_set #(.SIZE(IP_SET_SIZE), .W(IP_W)) u_dst_ip (
    .clk, .rst_n, .key(k_dip), .do_insert(ins[SET_DST_IP]), .do_erase(ers[SET_DST_IP]),
    .hit(hit[SET_DST_IP]), .is_empty(empty[SET_DST_IP]), .is_full(full[SET_DST_IP]));
  ipf_set #(.SIZE(PORT_SET_SIZE), .W(PORT_W)) u_src_port (
    .clk, .rst_n, .key(k_sp), .do_insert(ins[SET_SRC_PORT]),
    .do_erase(ers[SET_SRC_PORT]), .hit(hit[SET_SRC_PORT]),
    .is_empty(empty[SET_SRC_PORT]), .is_full(full[SET_SRC_PORT]));
  ipf_set #(.SIZE(PORT_SET_SIZE), .W(PORT_W)) u_dst_port (
    .clk, .rst_n, .key(k_dp), .do_insert(ins[SET_DST_PORT]),
    .do_erase(ers[SET_DST_PORT]), .hit(hit[SET_DST_PORT]),
    .is_empty(empty[SET_DST_PORT]), .is_full(full[SET_DST_PORT]));
  ipf_set #(.SIZE(PROTO_SET_SIZE), .W(PROTO_W)) u_proto (
    .clk, .rst_n, .key(k_pr), .do_insert(ins[SET_PROTO]), .do_erase(ers[SET_PROTO]),
    .hit(hit[SET_PROTO]), .is_empty(empty[SET_PROTO]), .is_full(full[SET_PROTO]));

  // an empty set matches everything
  assign base_ok  = (empty[SET_SRC_IP] || hit[SET_SRC_IP])
                 && (empty[SET_DST_IP] || hit[SET_DST_IP])
                 && (empty[SET_PROTO] || hit[SET_PROTO]);
  assign ports_ok = (empty[SET_SRC_PORT] || hit[SET_SRC_PORT])
                 && (empty[SET_DST_PORT] || hit[SET_DST_PORT]);
  assign no_ports = empty[SET_SRC_PORT] && empty[SET_DST_PORT];

  always_comb begin
    res = '0;
    unique case (work.op)
      OP_CLASSIFY: begin
        res.transport_kind = work.kind;
        unique case (work.kind)
          KIND_UDP, KIND_TCP: res.accept = base_ok && ports_ok;
          KIND_ICMP:          res.accept = base_ok && no_ports;
          default:            res.accept = 1'b0;
        endcase
      end
      OP_INSERT: begin
        res.status = (|(work.sel & full & ~hit)) ? STATUS_FULL : STATUS_OK;
      end
      default: res = '0;
    endcase
  end

  assign out_empty = (cnt_r == '0);
  assign pop       = out_pop && !out_empty;
  assign out_word  = rq_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = fire ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(fire) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rq_r[wr_ptr_r] <= res;
    end
  end

  a_no_fire_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == QCNT_W'(QUEUE_DEPTH) |-> !fire)
    else $error("result written into full result queue");

  a_edit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !classify |-> !res.accept && res.transport_kind == KIND_OTHER)
    else $error("set edit produced classify fields");

endmodule

// ===== rtl/core/ip_five_set_packet_filter.sv =====
// top level of the five-set packet filter
//
//  channel | direction | handshake          | word
//  in_     | input     | in_push / in_full   | ipf_pkg::in_word_t
//  out_    | output    | out_pop / out_empty | ipf_pkg::out_word_t
//
// sustains one word per cycle while the result queue has room: the back end runs a word
// against all set slots in parallel compares.
// a word is registered in the work queue, its result in the result queue, before a pop.
// reset clears all slot valid bits and both two-entry queues; slot keys are not reset.
// in_full rises when the two-entry work queue holds two words; the back end
// stalls only while the two-entry result queue is full.
module ip_five_set_packet_filter #(
  parameter int IP_SET_SIZE    = 16,
  parameter int PORT_SET_SIZE  = 16,
  parameter int PROTO_SET_SIZE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ipf_pkg::in_word_t  in_word,
  output logic               out_empty,
  input  logic               out_pop,
  output ipf_pkg::out_word_t out_word
);
  import ipf_pkg::*;

  work_t work;
  logic  work_valid;
  logic  work_pop;

  ipf_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_word,
    .work_valid, .work_pop, .work
  );

  ipf_back #(
    .IP_SET_SIZE(IP_SET_SIZE),
    .PORT_SET_SIZE(PORT_SET_SIZE),
    .PROTO_SET_SIZE(PROTO_SET_SIZE)
  ) u_back (
    .clk, .rst_n, .work_valid, .work_pop, .work,
    .out_empty, .out_pop, .out_word
  );

endmodule
